FILE: design/l4snat_pkg.sv
`timescale 1ns / 1ps
package l4snat_pkg;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam int unsigned ETH_LEN        = 14;
  localparam int unsigned IPV4_MIN_LEN   = 20;
  localparam int unsigned TCP_HDR_LEN    = 20;
  localparam int unsigned UDP_HDR_LEN    = 8;
  localparam logic [15:0] L4_OFFSET      = 16'(ETH_LEN + IPV4_MIN_LEN);
  localparam logic [15:0] TCP_MIN_LEN    = 16'(ETH_LEN + IPV4_MIN_LEN + TCP_HDR_LEN);
  localparam logic [15:0] UDP_MIN_LEN    = 16'(ETH_LEN + IPV4_MIN_LEN + UDP_HDR_LEN);
  localparam logic [3:0]  IPV4_MIN_WORDS = 4'd5;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  typedef struct packed {
    logic [15:0] pkt_len;
    logic [15:0] ether_type;
    logic [3:0]  ip_hdr_words;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [15:0] ip_checksum;
    logic [15:0] src_port_in;
    logic [15:0] l4_checksum;
    logic        table_hit;
    logic [31:0] orig_addr;
    logic [15:0] orig_port;
  } in_item_t;

  typedef struct packed {
    logic        rewritten;
    logic [31:0] out_src_addr;
    logic [15:0] out_src_port;
    logic [15:0] out_ip_checksum;
    logic [15:0] out_l4_checksum;
    logic [63:0] packets_done;
    logic [63:0] bytes_done;
  } out_item_t;

  // header rewrite result, without the running counters
  typedef struct packed {
    logic        rewritten;
    logic [31:0] src_addr;
    logic [15:0] sport;
    logic [15:0] ip_checksum;
    logic [15:0] l4_checksum;
  } rw_res_t;

  // counter update request
  typedef struct packed {
    logic        inc;
    logic [15:0] len;
  } cnt_upd_t;

  // end-around carry fold of a sum of up to five 16-bit words
  function automatic logic [15:0] oc_fold(input logic [18:0] s);
    logic [16:0] t;
    logic [15:0] u;
    t = {1'b0, s[15:0]} + {14'd0, s[18:16]};
    u = t[15:0] + {15'd0, t[16]};
    return u;
  endfunction

  // one 16-bit word changes: HC' = ~(~HC + ~m + m')
  function automatic logic [15:0] csum_upd16(input logic [15:0] hc,
                                             input logic [15:0] oldw,
                                             input logic [15:0] neww);
    logic [18:0] s;
    s = {3'd0, ~hc} + {3'd0, ~oldw} + {3'd0, neww};
    return ~oc_fold(s);
  endfunction

  // one 32-bit value changes, taken as two words
  function automatic logic [15:0] csum_upd32(input logic [15:0] hc,
                                             input logic [31:0] oldv,
                                             input logic [31:0] newv);
    logic [18:0] s;
    s = {3'd0, ~hc} + {3'd0, ~oldv[31:16]} + {3'd0, ~oldv[15:0]}
      + {3'd0, newv[31:16]} + {3'd0, newv[15:0]};
    return ~oc_fold(s);
  endfunction

endpackage

FILE: design/l4snat_rewrite.sv
`timescale 1ns / 1ps
module l4snat_rewrite import l4snat_pkg::*; (
  input  in_item_t item,
  output rw_res_t  res
);

  logic        is_tcp;
  logic        is_udp;
  logic        qualify;
  logic        l4_present;
  logic [15:0] l4_step1;
  logic [15:0] l4_step2;

  assign is_tcp = (item.ip_protocol == PROTO_TCP);
  assign is_udp = (item.ip_protocol == PROTO_UDP);

  assign qualify = (item.ether_type == ETHERTYPE_IPV4)
                && (item.pkt_len >= L4_OFFSET)
                && (item.ip_hdr_words >= IPV4_MIN_WORDS)
                && ((is_tcp && (item.pkt_len >= TCP_MIN_LEN))
                 || (is_udp && (item.pkt_len >= UDP_MIN_LEN)))
                && item.table_hit;

  // zero UDP checksum means no checksum; leave it alone
  assign l4_present = is_tcp || (item.l4_checksum != 16'd0);

  // port first, then the pseudo-header source address
  assign l4_step1 = csum_upd16(item.l4_checksum, item.src_port_in, item.orig_port);
  assign l4_step2 = csum_upd32(l4_step1, item.src_addr, item.orig_addr);

  always_comb begin
    res.rewritten   = 1'b0;
    res.src_addr    = item.src_addr;
    res.sport       = item.src_port_in;
    res.ip_checksum = item.ip_checksum;
    res.l4_checksum = item.l4_checksum;
    if (qualify) begin
      res.rewritten   = 1'b1;
      res.src_addr    = item.orig_addr;
      res.sport       = item.orig_port;
      res.ip_checksum = csum_upd32(item.ip_checksum, item.src_addr, item.orig_addr);
      if (l4_present) begin
        // UDP sends all ones in place of a computed zero
        if (is_udp && (l4_step2 == 16'd0)) begin
          res.l4_checksum = 16'hFFFF;
        end else begin
          res.l4_checksum = l4_step2;
        end
      end
    end
  end

endmodule

FILE: design/l4snat_counters.sv
`timescale 1ns / 1ps
module l4snat_counters import l4snat_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cnt_upd_t    upd,
  output logic [63:0] packets_nxt,
  output logic [63:0] bytes_nxt
);

  logic [63:0] pkt_cnt_r;
  logic [63:0] byte_cnt_r;

  // values after the current transaction; wrap naturally
  assign packets_nxt = upd.inc ? pkt_cnt_r + 64'd1 : pkt_cnt_r;
  assign bytes_nxt   = upd.inc ? byte_cnt_r + {48'd0, upd.len} : byte_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_cnt_r  <= 64'd0;
      byte_cnt_r <= 64'd0;
    end else begin
      pkt_cnt_r  <= packets_nxt;
      byte_cnt_r <= bytes_nxt;
    end
  end

endmodule

FILE: design/l4snat_top_dummy_guard.sv
`timescale 1ns / 1ps
// Holding stage for one header transaction: captures on accept and keeps
// the header until the result stage takes it.
module l4snat_top_dummy_guard import l4snat_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  logic     drain,
  input  in_item_t din,
  output logic     valid,
  output in_item_t dout
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;

  assign valid_nxt = load ? 1'b1 : (drain ? 1'b0 : valid_r);
  assign valid     = valid_r;
  assign dout      = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

endmodule

FILE: design/l4_reverse_snat_rewrite_top.sv
`timescale 1ns / 1ps
// Reverse source NAT rewrite for IPv4 TCP/UDP return traffic. Each input
// transaction carries one packet's header fields plus the connection table
// lookup result; each yields exactly one result transaction. A qualifying
// packet (IPv4, header length of at least 5 words, TCP with at least 54
// bytes or UDP with at least 42 bytes, table hit) gets its source address
// and port replaced, and the IP and L4 checksums patched incrementally
// (ones-complement, L4 includes the pseudo-header address; an absent UDP
// checksum stays zero, a computed zero UDP checksum goes out as 0xFFFF).
// Anything else passes through unchanged with rewritten low. The 64-bit
// packet and byte counters wrap and are reported after each transaction.
// Throughput is one transaction per clock while out_stall is low. An
// accepted transaction is held in the input register, then the checksum
// adders and counter increment feed the result register, which drives
// out_valid. The result register backs up on out_stall, and in_stall
// rises only when both the input register and the result register are full
// and out_stall is high.
module l4_reverse_snat_rewrite_top import l4snat_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      s1_valid;
  in_item_t  s1_data;
  logic      s1_adv;
  logic      in_accept;
  logic      out_accept;
  rw_res_t   res;
  cnt_upd_t  cnt_upd;
  logic [63:0] packets_nxt;
  logic [63:0] bytes_nxt;

  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;

  // stage 1 moves forward when the result register is empty or draining
  assign s1_adv     = s1_valid && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid && out_valid_r && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid_r && !out_stall;

  l4snat_top_dummy_guard u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (in_accept),
    .drain (s1_adv),
    .din   (in_data),
    .valid (s1_valid),
    .dout  (s1_data)
  );

  l4snat_rewrite u_rewrite (
    .item (s1_data),
    .res  (res)
  );

  // counters only move when the transaction lands in the result register
  assign cnt_upd.inc = s1_adv && res.rewritten;
  assign cnt_upd.len = s1_data.pkt_len;

  l4snat_counters u_counters (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd         (cnt_upd),
    .packets_nxt (packets_nxt),
    .bytes_nxt   (bytes_nxt)
  );

  assign out_valid_nxt = s1_adv ? 1'b1 : (out_accept ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r.rewritten       <= res.rewritten;
      out_data_r.out_src_addr    <= res.src_addr;
      out_data_r.out_src_port    <= res.sport;
      out_data_r.out_ip_checksum <= res.ip_checksum;
      out_data_r.out_l4_checksum <= res.l4_checksum;
      out_data_r.packets_done    <= packets_nxt;
      out_data_r.bytes_done      <= bytes_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // back-pressure reaches the input only with both stages full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid && out_valid_r && out_stall))
    else $error("in_stall raised with a free stage");

  // a held header must not be lost while the result stage is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_data)))
    else $error("stage 1 transaction dropped or changed while blocked");

  // a new result only comes from a full stage 1
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(s1_valid))
    else $error("result appeared without a source transaction");

  // a result loaded with no rewrite must keep the counters where they were
  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !res.rewritten) |-> (cnt_upd.inc == 1'b0))
    else $error("counter increment on a pass-through transaction");

endmodule
